// ----- rtl/adp_pkg.sv -----
// Shared types, constants and record layout of the advertising data parser.
// Used by adp_core, adp_out_queue and advertising_data_parser_unit.
`default_nettype none

package adp_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int NAME_MAX_DEF    = 32;
    localparam int SERVICE_MAX_DEF = 8;
    localparam int MFG_MAX_DEF     = 32;
    localparam int BUFFER_MAX_DEF  = 64;

    // Output queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // Advertising data structure types that the parser recognizes.
    localparam logic [7:0] AD_SVC16_PARTIAL  = 8'h02;
    localparam logic [7:0] AD_SVC16_COMPLETE = 8'h03;
    localparam logic [7:0] AD_NAME_SHORT     = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE  = 8'h09;
    localparam logic [7:0] AD_TX_POWER       = 8'h0A;
    localparam logic [7:0] AD_MFG_SPECIFIC   = 8'hFF;

    typedef enum logic [2:0] {
        KIND_NAME    = 3'd0,
        KIND_UUID    = 3'd1,
        KIND_MFG     = 3'd2,
        KIND_TXPOWER = 3'd3,
        KIND_SUMMARY = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STOP_NONE    = 2'd0,
        STOP_ZERO    = 2'd1,
        STOP_OVERRUN = 2'd2
    } t_stop;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [5:0]  position;
        logic [4:0]  name_length;
        logic [3:0]  uuid_count;
        logic [5:0]  mfg_length;
        logic        name_seen;
        logic        services_seen;
        t_stop       stop_reason;
        logic        end_of_buffer;
    } t_record;

    // Records produced by one item: a field record and the summary.
    typedef struct packed {
        logic    field_valid;
        t_record field_rec;
        logic    summary_valid;
        t_record summary_rec;
    } t_rec_pair;

endpackage

`default_nettype wire

// ----- rtl/adp_core.sv -----
// Parse state and record generation for one buffer byte per cycle while i_valid is high.
// Depends on adp_pkg.
`default_nettype none

module adp_core
    import adp_pkg::*;
#(
    parameter int NAME_MAX    = NAME_MAX_DEF,
    parameter int SERVICE_MAX = SERVICE_MAX_DEF,
    parameter int MFG_MAX     = MFG_MAX_DEF,
    parameter int BUFFER_MAX  = BUFFER_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic [6:0] i_length,
    output t_rec_pair       o_recs
);

    localparam int PosW     = $clog2(BUFFER_MAX + 1);
    localparam int NameLenW = $clog2(NAME_MAX);
    localparam int UuidW    = $clog2(SERVICE_MAX + 1);
    localparam int MfgW     = $clog2(MFG_MAX + 1);

    logic [PosW-1:0]     r_pos, r_total, e_pos, e_total, n_pos;
    logic [7:0]          r_rem, e_rem, n_rem;
    logic [7:0]          r_type, e_type, n_type;
    logic [7:0]          r_off, e_off, n_off;
    logic [7:0]          r_low, e_low, n_low;
    logic [NameLenW-1:0] r_name_len, e_name_len, n_name_len;
    logic [UuidW-1:0]    r_uuid_cnt, e_uuid_cnt, n_uuid_cnt;
    logic [MfgW-1:0]     r_mfg_len, e_mfg_len, n_mfg_len;
    logic                r_name_seen, e_name_seen, n_name_seen;
    logic                r_svc_seen, e_svc_seen, n_svc_seen;
    t_stop               r_stop, e_stop, n_stop;
    t_phase              r_phase, e_phase, n_phase;

    logic [7:0] len8, len_clamped;
    logic       active;
    logic [7:0] rem_dec;
    logic       overrun;
    logic [7:0] uuid_cnt8, name_len8, mfg_len8;

    // A buffer start clears the state before the byte is handled.
    always_comb begin
        len8        = {1'b0, i_length};
        len_clamped = len8;
        if (len8 == 8'd0) begin
            len_clamped = 8'd1;
        end else if (len8 > 8'(BUFFER_MAX)) begin
            len_clamped = 8'(BUFFER_MAX);
        end
        if (i_start) begin
            e_pos       = '0;
            e_total     = PosW'(len_clamped);
            e_rem       = '0;
            e_type      = '0;
            e_off       = '0;
            e_low       = '0;
            e_name_len  = '0;
            e_uuid_cnt  = '0;
            e_mfg_len   = '0;
            e_name_seen = 1'b0;
            e_svc_seen  = 1'b0;
            e_stop      = STOP_NONE;
            e_phase     = PH_LEN;
        end else begin
            e_pos       = r_pos;
            e_total     = r_total;
            e_rem       = r_rem;
            e_type      = r_type;
            e_off       = r_off;
            e_low       = r_low;
            e_name_len  = r_name_len;
            e_uuid_cnt  = r_uuid_cnt;
            e_mfg_len   = r_mfg_len;
            e_name_seen = r_name_seen;
            e_svc_seen  = r_svc_seen;
            e_stop      = r_stop;
            e_phase     = r_phase;
        end
    end

    assign active  = (e_pos < e_total);
    assign rem_dec = e_rem - 8'd1;
    assign overrun = (10'(e_pos) + 10'd1 + 10'(i_byte)) > 10'(e_total);

    // Next parse phase.
    always_comb begin
        n_phase = e_phase;
        if (active) begin
            unique case (e_phase)
                PH_LEN: begin
                    if (i_byte == 8'd0 || overrun) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: n_phase = (rem_dec != 8'd0) ? PH_DATA : PH_LEN;
                PH_DATA: n_phase = (rem_dec == 8'd0) ? PH_LEN : PH_DATA;
                PH_STOP: n_phase = PH_STOP;
                default: n_phase = PH_STOP;
            endcase
        end
    end

    // Field state, summary counters and records.
    always_comb begin
        n_pos       = e_pos;
        n_rem       = e_rem;
        n_type      = e_type;
        n_off       = e_off;
        n_low       = e_low;
        n_name_len  = e_name_len;
        n_uuid_cnt  = e_uuid_cnt;
        n_mfg_len   = e_mfg_len;
        n_name_seen = e_name_seen;
        n_svc_seen  = e_svc_seen;
        n_stop      = e_stop;
        uuid_cnt8   = 8'(e_uuid_cnt);

        o_recs                           = '0;
        o_recs.field_rec.kind            = KIND_NAME;
        o_recs.field_rec.stop_reason     = STOP_NONE;
        o_recs.summary_rec.kind          = KIND_SUMMARY;
        o_recs.summary_rec.stop_reason   = STOP_NONE;

        if (active) begin
            unique case (e_phase)
                PH_LEN: begin
                    if (i_byte == 8'd0) begin
                        n_stop = STOP_ZERO;
                    end else if (overrun) begin
                        n_stop = STOP_OVERRUN;
                    end else begin
                        n_rem = i_byte;
                    end
                end
                PH_TYPE: begin
                    n_type = i_byte;
                    n_off  = 8'd0;
                    n_rem  = rem_dec;
                    if (i_byte == AD_NAME_SHORT || i_byte == AD_NAME_COMPLETE) begin
                        n_name_seen = 1'b1;
                        n_name_len  = '0;
                    end else if (i_byte == AD_SVC16_PARTIAL ||
                                 i_byte == AD_SVC16_COMPLETE) begin
                        n_svc_seen = 1'b1;
                        n_uuid_cnt = '0;
                    end else if (i_byte == AD_MFG_SPECIFIC) begin
                        n_mfg_len = '0;
                    end
                end
                PH_DATA: begin
                    if (e_type == AD_NAME_SHORT || e_type == AD_NAME_COMPLETE) begin
                        if (e_off < 8'(NAME_MAX - 1)) begin
                            o_recs.field_valid        = 1'b1;
                            o_recs.field_rec.kind     = KIND_NAME;
                            o_recs.field_rec.value    = {8'd0, i_byte};
                            o_recs.field_rec.position = e_off[5:0];
                            n_name_len = NameLenW'(e_off + 8'd1);
                        end
                    end else if (e_type == AD_SVC16_PARTIAL ||
                                 e_type == AD_SVC16_COMPLETE) begin
                        if (!e_off[0]) begin
                            n_low = i_byte;
                        end else if (e_uuid_cnt < UuidW'(SERVICE_MAX)) begin
                            o_recs.field_valid        = 1'b1;
                            o_recs.field_rec.kind     = KIND_UUID;
                            o_recs.field_rec.value    = {i_byte, e_low};
                            o_recs.field_rec.position = uuid_cnt8[5:0];
                            n_uuid_cnt = e_uuid_cnt + UuidW'(1);
                        end
                    end else if (e_type == AD_MFG_SPECIFIC) begin
                        if (e_off < 8'(MFG_MAX)) begin
                            o_recs.field_valid        = 1'b1;
                            o_recs.field_rec.kind     = KIND_MFG;
                            o_recs.field_rec.value    = {8'd0, i_byte};
                            o_recs.field_rec.position = e_off[5:0];
                            n_mfg_len = MfgW'(e_off + 8'd1);
                        end
                    end else if (e_type == AD_TX_POWER) begin
                        if (e_off == 8'd0) begin
                            o_recs.field_valid     = 1'b1;
                            o_recs.field_rec.kind  = KIND_TXPOWER;
                            o_recs.field_rec.value = {8'd0, i_byte};
                        end
                    end
                    n_off = e_off + 8'd1;
                    n_rem = rem_dec;
                end
                PH_STOP: begin
                end
                default: begin
                end
            endcase
            n_pos = e_pos + PosW'(1);
        end

        name_len8 = 8'(n_name_len);
        mfg_len8  = 8'(n_mfg_len);
        if (active && n_pos == e_total) begin
            o_recs.summary_valid               = 1'b1;
            o_recs.summary_rec.name_length     = name_len8[4:0];
            o_recs.summary_rec.uuid_count      = 4'(n_uuid_cnt);
            o_recs.summary_rec.mfg_length      = mfg_len8[5:0];
            o_recs.summary_rec.name_seen       = n_name_seen;
            o_recs.summary_rec.services_seen   = n_svc_seen;
            o_recs.summary_rec.stop_reason     = n_stop;
            o_recs.summary_rec.end_of_buffer   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_total     <= '0;
            r_rem       <= '0;
            r_type      <= '0;
            r_off       <= '0;
            r_low       <= '0;
            r_name_len  <= '0;
            r_uuid_cnt  <= '0;
            r_mfg_len   <= '0;
            r_name_seen <= 1'b0;
            r_svc_seen  <= 1'b0;
            r_stop      <= STOP_NONE;
            r_phase     <= PH_LEN;
        end else if (i_valid) begin
            r_pos       <= n_pos;
            r_total     <= e_total;
            r_rem       <= n_rem;
            r_type      <= n_type;
            r_off       <= n_off;
            r_low       <= n_low;
            r_name_len  <= n_name_len;
            r_uuid_cnt  <= n_uuid_cnt;
            r_mfg_len   <= n_mfg_len;
            r_name_seen <= n_name_seen;
            r_svc_seen  <= n_svc_seen;
            r_stop      <= n_stop;
            r_phase     <= n_phase;
        end
    end

    // The byte counter never passes the buffer length.
    a_pos_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_total)
        else $error("byte position passed the buffer length");

    // A started buffer always has a nonzero length.
    a_total_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_start) |=> (r_total != '0))
        else $error("buffer started with zero length");

    // Parsing only stops together with a recorded stop reason.
    a_stop_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP) |-> (r_stop != STOP_NONE))
        else $error("parse stopped without a stop reason");

endmodule

`default_nettype wire

// ----- rtl/adp_out_queue.sv -----
// Small record queue: takes up to two records per cycle, hands out one while i_ready is high.
// Depends on adp_pkg.
`default_nettype none

module adp_out_queue
    import adp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_rec_pair i_recs,
    input  wire logic      i_push,
    output logic           o_room,
    output logic           o_valid,
    output t_record        o_rec,
    input  wire logic      i_ready
);

    t_record           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr, b_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push_a, push_b, pop;

    assign push_a  = i_push && i_recs.field_valid;
    assign push_b  = i_push && i_recs.summary_valid;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_rec   = r_mem[r_rd_ptr];
    // Room for the two records that one item may bring.
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        b_ptr    = r_wr_ptr + QPTR_W'(push_a);
        n_wr_ptr = r_wr_ptr + QPTR_W'(push_a) + QPTR_W'(push_b);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_a) begin
            r_mem[r_wr_ptr] <= i_recs.field_rec;
        end
        if (push_b) begin
            r_mem[b_ptr] <= i_recs.summary_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("record queue overflowed");

    a_push_has_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_a || push_b) |-> o_room)
        else $error("record written without room");

    a_ptr_distance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ----- rtl/advertising_data_parser_unit.sv -----
// Top level of the advertising data parser: stream ports, parse core, record queue.
// Depends on adp_pkg, adp_core and adp_out_queue.
//
//  Channel   Dir  Ports                          Contents
//  --------  ---  -----------------------------  ------------------------------------
//  byte in   in   i_s_tvalid/o_s_tready/tdata    ad_byte, buffer_length; tuser start
//  record    out  o_m_tvalid/i_m_tready/tdata    record fields; tuser kind; tlast end
//
// Each input item (one buffer byte) is taken on its handshake; the parse state and the
// records it causes are settled in that same cycle and written to a four-record queue.
// The next byte can be taken in the following cycle, so the input runs at one item per
// cycle while the queue has room. The final byte of a buffer can yield two records, so
// ready drops while the queue holds more than two records.
// Reset (i_rst_n low at a clock edge) clears the parse state and empties the queue.
`default_nettype none

module advertising_data_parser_unit
    import adp_pkg::*;
#(
    parameter int NAME_MAX    = NAME_MAX_DEF,
    parameter int SERVICE_MAX = SERVICE_MAX_DEF,
    parameter int MFG_MAX     = MFG_MAX_DEF,
    parameter int BUFFER_MAX  = BUFFER_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input item stream.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // [7:0] ad_byte, [14:8] buffer_length, [15] zero.
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // [0] buffer_start.
    input  wire logic                 i_s_tuser,
    // Record stream.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [15:0] record_value, [21:16] record_position, [26:22] name_length,
    // [30:27] uuid_count, [36:31] manufacturer_length, [37] name_seen,
    // [38] services_seen, [40:39] stop_reason, [47:41] zero.
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // [2:0] record_kind.
    output logic [M_TUSER_W-1:0]      o_m_tuser,
    // end_of_buffer: set on the summary record.
    output logic                      o_m_tlast
);

    logic      in_accept;
    logic      q_room;
    t_rec_pair recs;
    t_record   out_rec;

    assign o_s_tready = q_room;
    assign in_accept  = i_s_tvalid && q_room;

    // Byte-level parser: a new item enters whenever the queue has room.
    adp_core #(
        .NAME_MAX    (NAME_MAX),
        .SERVICE_MAX (SERVICE_MAX),
        .MFG_MAX     (MFG_MAX),
        .BUFFER_MAX  (BUFFER_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_accept),
        .i_byte   (i_s_tdata[7:0]),
        .i_start  (i_s_tuser),
        .i_length (i_s_tdata[14:8]),
        .o_recs   (recs)
    );

    // The queue keeps the input side moving while a record waits downstream.
    adp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_recs  (recs),
        .i_push  (in_accept),
        .o_room  (q_room),
        .o_valid (o_m_tvalid),
        .o_rec   (out_rec),
        .i_ready (i_m_tready)
    );

    // Pack the record fields, first field in the lowest bits.
    assign o_m_tdata = {7'd0,
                        out_rec.stop_reason,
                        out_rec.services_seen,
                        out_rec.name_seen,
                        out_rec.mfg_length,
                        out_rec.uuid_count,
                        out_rec.name_length,
                        out_rec.position,
                        out_rec.value};
    assign o_m_tuser = out_rec.kind;
    assign o_m_tlast = out_rec.end_of_buffer;

endmodule

`default_nettype wire

// ----- sim/tb_advertising_data_parser_unit.sv -----
// Self-checking testbench for advertising_data_parser_unit: buffers of advertising bytes
// go in one item at a time, and every record that comes out is compared with a prediction.
// Depends on adp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_advertising_data_parser_unit;
    import adp_pkg::*;

    // Ways of filling a buffer: proper structures, structures ending in a stop, raw noise.
    localparam int FRAME_CLEAN  = 0;
    localparam int FRAME_BROKEN = 1;
    localparam int FRAME_NOISE  = 2;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // [7:0] ad_byte, [14:8] buffer_length, [15] zero.
    logic [S_TDATA_W-1:0] i_s_tdata;
    // [0] buffer_start.
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // [15:0] value, [21:16] position, [26:22] name_length, [30:27] uuid_count,
    // [36:31] manufacturer_length, [37] name_seen, [38] services_seen, [40:39] stop_reason.
    logic [M_TDATA_W-1:0] o_m_tdata;
    // [2:0] record_kind.
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_m_tlast;

    advertising_data_parser_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Predicted parser state, one copy kept alongside the block.
    int          cur_pos;
    int          buf_len;
    logic [7:0]  struct_left;
    t_phase      parse_ph;
    logic [7:0]  ad_type;
    logic [7:0]  elem_idx;
    logic [7:0]  uuid_lsb;
    int          name_len;
    int          uuid_cnt;
    int          mfg_len;
    logic        name_flag;
    logic        svc_flag;
    t_stop       stop_why;

    // Records that the parser still owes, oldest first.
    t_record     pending_records[$];
    logic [7:0]  frame_bytes[$];

    int          mismatch_count  = 0;
    int          live_items      = 0;
    int          buffers_started = 0;
    int          records_seen    = 0;
    int          summaries_seen  = 0;
    int          hold_off_cycles = 0;
    bit          src_idle_on     = 1'b1;
    bit          sink_idle_on    = 1'b1;
    bit          rst_done        = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("end of test: mismatches");
        $finish;
    end

    // Clears everything that belongs to one buffer.
    task automatic clear_buffer_state();
        cur_pos     = 0;
        buf_len     = 0;
        struct_left = 8'd0;
        parse_ph    = PH_LEN;
        ad_type     = 8'd0;
        elem_idx    = 8'd0;
        uuid_lsb    = 8'd0;
        name_len    = 0;
        uuid_cnt    = 0;
        mfg_len     = 0;
        name_flag   = 1'b0;
        svc_flag    = 1'b0;
        stop_why    = STOP_NONE;
    endtask

    function automatic t_record field_record(t_kind k, logic [15:0] v, logic [5:0] p);
        t_record r;
        r          = '0;
        r.kind     = k;
        r.value    = v;
        r.position = p;
        return r;
    endfunction

    // Advances the predicted state by one accepted byte and queues the records it causes.
    task automatic parse_byte(input logic [7:0] b, input logic st, input logic [6:0] blen);
        t_record sum;
        if (st) begin
            clear_buffer_state();
            buf_len = int'(blen);
            if (buf_len == 0)
                buf_len = 1;
            if (buf_len > BUFFER_MAX_DEF)
                buf_len = BUFFER_MAX_DEF;
            buffers_started++;
        end
        // Bytes outside a buffer are dropped without any record.
        if (cur_pos >= buf_len)
            return;
        live_items++;
        case (parse_ph)
            PH_LEN: begin
                if (b == 8'd0) begin
                    stop_why = STOP_ZERO;
                    parse_ph = PH_STOP;
                end else if (cur_pos + 1 + int'(b) > buf_len) begin
                    stop_why = STOP_OVERRUN;
                    parse_ph = PH_STOP;
                end else begin
                    struct_left = b;
                    parse_ph    = PH_TYPE;
                end
            end
            PH_TYPE: begin
                ad_type     = b;
                elem_idx    = 8'd0;
                struct_left = struct_left - 8'd1;
                if (b == AD_NAME_SHORT || b == AD_NAME_COMPLETE) begin
                    name_flag = 1'b1;
                    name_len  = 0;
                end else if (b == AD_SVC16_PARTIAL || b == AD_SVC16_COMPLETE) begin
                    svc_flag = 1'b1;
                    uuid_cnt = 0;
                end else if (b == AD_MFG_SPECIFIC) begin
                    mfg_len = 0;
                end
                if (struct_left != 8'd0)
                    parse_ph = PH_DATA;
                else
                    parse_ph = PH_LEN;
            end
            PH_DATA: begin
                if (ad_type == AD_NAME_SHORT || ad_type == AD_NAME_COMPLETE) begin
                    // Names are kept up to one byte short of the name store.
                    if (int'(elem_idx) < NAME_MAX_DEF - 1) begin
                        pending_records.push_back(field_record(KIND_NAME, {8'd0, b},
                                                               elem_idx[5:0]));
                        name_len = int'(elem_idx) + 1;
                    end
                end else if (ad_type == AD_SVC16_PARTIAL || ad_type == AD_SVC16_COMPLETE) begin
                    // Low byte first; an odd byte at the end of the list never pairs up.
                    if (!elem_idx[0]) begin
                        uuid_lsb = b;
                    end else if (uuid_cnt < SERVICE_MAX_DEF) begin
                        pending_records.push_back(field_record(KIND_UUID, {b, uuid_lsb},
                                                               uuid_cnt[5:0]));
                        uuid_cnt++;
                    end
                end else if (ad_type == AD_MFG_SPECIFIC) begin
                    if (int'(elem_idx) < MFG_MAX_DEF) begin
                        pending_records.push_back(field_record(KIND_MFG, {8'd0, b},
                                                               elem_idx[5:0]));
                        mfg_len = int'(elem_idx) + 1;
                    end
                end else if (ad_type == AD_TX_POWER) begin
                    if (elem_idx == 8'd0)
                        pending_records.push_back(field_record(KIND_TXPOWER, {8'd0, b}, 6'd0));
                end
                elem_idx    = elem_idx + 8'd1;
                struct_left = struct_left - 8'd1;
                if (struct_left == 8'd0)
                    parse_ph = PH_LEN;
            end
            default: begin
            end
        endcase
        cur_pos++;
        // The final byte of the buffer is counted even after a stop and closes it.
        if (cur_pos == buf_len) begin
            sum               = field_record(KIND_SUMMARY, 16'd0, 6'd0);
            sum.name_length   = 5'(name_len);
            sum.uuid_count    = 4'(uuid_cnt);
            sum.mfg_length    = 6'(mfg_len);
            sum.name_seen     = name_flag;
            sum.services_seen = svc_flag;
            sum.stop_reason   = stop_why;
            sum.end_of_buffer = 1'b1;
            pending_records.push_back(sum);
        end
    endtask

    // Offers one item, waits for the handshake, then updates the prediction.
    task automatic send_item(input logic [7:0] b, input logic st, input logic [6:0] blen);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, blen, b};
        i_s_tuser  <= st;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        parse_byte(b, st, blen);
    endtask

    // Sends the first count bytes of frame_bytes as one buffer; the length rides on the first.
    task automatic send_frame(input logic [6:0] len_field, input int count);
        logic [6:0] junk_len;
        for (int i = 0; i < count; i++) begin
            junk_len = 7'($urandom_range(0, 127));
            if (i == 0)
                send_item(frame_bytes[i], 1'b1, len_field);
            else
                send_item(frame_bytes[i], 1'b0, junk_len);
        end
    endtask

    // Mostly short buffers, with the full size, zero and oversized lengths mixed in.
    function automatic logic [6:0] pick_length();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 7'd0;
        else if (k == 1)
            return 7'($urandom_range(BUFFER_MAX_DEF + 1, 127));
        else if (k < 4)
            return 7'(BUFFER_MAX_DEF);
        else if (k < 8)
            return 7'($urandom_range(31, BUFFER_MAX_DEF - 1));
        else
            return 7'($urandom_range(1, 16));
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 7))
            0:       return AD_NAME_SHORT;
            1:       return AD_NAME_COMPLETE;
            2:       return AD_SVC16_PARTIAL;
            3:       return AD_SVC16_COMPLETE;
            4:       return AD_MFG_SPECIFIC;
            5:       return AD_TX_POWER;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Fills frame_bytes with eff bytes in the given style.
    task automatic build_frame(input int eff, input int style);
        int         room;
        int         slen;
        logic [7:0] bv;
        frame_bytes.delete();
        while (frame_bytes.size() < eff) begin
            room = eff - frame_bytes.size();
            bv   = 8'($urandom_range(0, 255));
            if (style == FRAME_NOISE) begin
                frame_bytes.push_back(bv);
            end else if (room == 1 || (style == FRAME_BROKEN && $urandom_range(0, 3) == 0)) begin
                // Close with a zero length or, when broken, possibly a length that overruns.
                if (style == FRAME_BROKEN && $urandom_range(0, 1) == 0)
                    bv = 8'($urandom_range(room, 255));
                else
                    bv = 8'd0;
                frame_bytes.push_back(bv);
                while (frame_bytes.size() < eff) begin
                    bv = 8'($urandom_range(0, 255));
                    frame_bytes.push_back(bv);
                end
            end else begin
                // Now and then one structure takes all that is left, so that long fields
                // run past their caps.
                if ($urandom_range(0, 4) == 0)
                    slen = room - 1;
                else
                    slen = $urandom_range(1, (room - 1 < 12) ? room - 1 : 12);
                frame_bytes.push_back(8'(slen));
                frame_bytes.push_back(pick_type());
                repeat (slen - 1) begin
                    bv = 8'($urandom_range(0, 255));
                    frame_bytes.push_back(bv);
                end
            end
        end
    endtask

    task automatic test_directed();
        // A byte before any buffer is dropped.
        send_item(8'hFF, 1'b0, 7'h7F);
        // Length zero counts as one byte, and that byte is a zero length.
        frame_bytes = '{8'h00};
        send_frame(7'd0, 1);
        // Name, uuid list with an odd trailing byte, tx power, manufacturer with no data.
        frame_bytes = '{8'h03, AD_NAME_COMPLETE, 8'h41, 8'h62,
                        8'h04, AD_SVC16_COMPLETE, 8'h34, 8'h12, 8'h56,
                        8'h02, AD_TX_POWER, 8'hC4,
                        8'h01, AD_MFG_SPECIFIC};
        send_frame(7'd14, 14);
        // A buffer abandoned by a new start gives no summary.
        frame_bytes = '{8'h02, AD_MFG_SPECIFIC, 8'h5A};
        send_frame(7'd10, 3);
        // A structure longer than the buffer stops parsing; later bytes still count.
        frame_bytes = '{8'h05, AD_MFG_SPECIFIC, 8'h01};
        send_frame(7'd3, 3);
        // A byte after the end of the buffer is dropped.
        send_item(8'h00, 1'b0, 7'd0);
    endtask

    task automatic test_random_buffers(input int item_goal);
        logic [6:0] lf;
        logic [7:0] bv;
        logic [6:0] jl;
        int         eff;
        int         k;
        int         style;
        int         cut;
        while (live_items < item_goal) begin
            // Most buffers see idling on both sides; some run without.
            src_idle_on  = ($urandom_range(0, 4) != 0);
            sink_idle_on = ($urandom_range(0, 4) != 0);
            lf  = pick_length();
            eff = (lf == 0) ? 1 : ((int'(lf) > BUFFER_MAX_DEF) ? BUFFER_MAX_DEF : int'(lf));
            k   = $urandom_range(0, 19);
            style = (k < 14) ? FRAME_CLEAN : ((k < 17) ? FRAME_BROKEN : FRAME_NOISE);
            build_frame(eff, style);
            cut = eff;
            if (eff > 1 && $urandom_range(0, 9) == 0)
                cut = $urandom_range(1, eff - 1);
            send_frame(lf, cut);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    bv = 8'($urandom_range(0, 255));
                    jl = 7'($urandom_range(0, 127));
                    send_item(bv, 1'b0, jl);
                end
            end
        end
    endtask

    // The receiver holds off for a long stretch while full buffers keep coming.
    task automatic test_output_hold();
        src_idle_on     = 1'b0;
        sink_idle_on    = 1'b0;
        hold_off_cycles = 300;
        repeat (2) begin
            build_frame(BUFFER_MAX_DEF, FRAME_CLEAN);
            send_frame(7'(BUFFER_MAX_DEF), BUFFER_MAX_DEF);
        end
    endtask

    // Last stretch runs back to back with no idling at all.
    task automatic test_quiet_tail(input int item_goal);
        logic [6:0] lf;
        int         eff;
        while (live_items < item_goal) begin
            src_idle_on  = 1'b0;
            sink_idle_on = 1'b0;
            lf  = pick_length();
            eff = (lf == 0) ? 1 : ((int'(lf) > BUFFER_MAX_DEF) ? BUFFER_MAX_DEF : int'(lf));
            build_frame(eff, ($urandom_range(0, 3) == 0) ? FRAME_BROKEN : FRAME_CLEAN);
            send_frame(lf, eff);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Output ready: random stalls, plus one long hold-off counted here.
    initial begin : sink_drive
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                i_m_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Every accepted record is compared with the oldest prediction.
    always @(posedge i_clk) begin : record_check
        t_record want;
        if (rst_done && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            records_seen++;
            if (o_m_tlast === 1'b1)
                summaries_seen++;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected record: expected none, actual kind %0h value %0h",
                         $time, o_m_tuser, o_m_tdata[15:0]);
                mismatch_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", 16'(want.kind), 16'(o_m_tuser));
                check_field("record_value", want.value, o_m_tdata[15:0]);
                check_field("record_position", 16'(want.position), 16'(o_m_tdata[21:16]));
                check_field("name_length", 16'(want.name_length), 16'(o_m_tdata[26:22]));
                check_field("uuid_count", 16'(want.uuid_count), 16'(o_m_tdata[30:27]));
                check_field("manufacturer_length", 16'(want.mfg_length),
                            16'(o_m_tdata[36:31]));
                check_field("name_seen", 16'(want.name_seen), 16'(o_m_tdata[37]));
                check_field("services_seen", 16'(want.services_seen), 16'(o_m_tdata[38]));
                check_field("stop_reason", 16'(want.stop_reason), 16'(o_m_tdata[40:39]));
                check_field("end_of_buffer", 16'(want.end_of_buffer), 16'(o_m_tlast));
            end
        end
    end

    initial begin : main_seq
        int guard;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        clear_buffer_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_buffers(820);
        test_output_hold();
        test_quiet_tail(1050);
        i_s_tvalid <= 1'b0;

        // Drain what is still owed, then keep the clock running so that stray records show up.
        guard = 0;
        while (pending_records.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_records.size() != 0) begin
            $display("%0t: %0d predicted records never arrived: expected 0, actual %0d",
                     $time, pending_records.size(), pending_records.size());
            mismatch_count++;
        end

        $display("Sent %0d buffer bytes across %0d buffers, including restarts and stops.",
                 live_items, buffers_started);
        $display("Checked %0d records, %0d of them buffer summaries; %0d mismatches.",
                 records_seen, summaries_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
